>>> sv/mvq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvq_pkg
// Shared constants, types and helpers for the mean-removed VQ block decoder.
// ---------------------------------------------------------------------------
package mvq_pkg;

  localparam int BLOCK_WIDTH      = 4;
  localparam int BLOCK_HEIGHT     = 4;
  localparam int CODEBOOK_ENTRIES = 256;

  localparam int PIXELS          = BLOCK_WIDTH * BLOCK_HEIGHT;
  localparam int WORDS_PER_BLOCK = PIXELS * 3;
  localparam int MAX_RESULTS     = 16;
  localparam int EMIT            = (PIXELS > MAX_RESULTS) ? MAX_RESULTS : PIXELS;
  localparam int CNT_W           = (EMIT > 1) ? $clog2(EMIT) : 1;

  localparam int PAL_AW    = $clog2(CODEBOOK_ENTRIES);
  localparam int RES_DEPTH = CODEBOOK_ENTRIES * PIXELS;
  localparam int RES_AW    = $clog2(RES_DEPTH);

  localparam int WORD_W    = 17;
  localparam int SUM_W     = WORD_W + 1;
  localparam int WT_W      = 16;
  localparam int PROD_W    = SUM_W + WT_W + 1;
  localparam int FRAC_BITS = 22;
  localparam int NUM_CH    = 3;

  localparam logic signed [PROD_W-1:0] MAX_CLAMP =
    PROD_W'(longint'(255) << FRAC_BITS);
  localparam logic signed [PROD_W-1:0] HALF_LSB =
    PROD_W'(longint'(1) << (FRAC_BITS - 1));

  localparam logic [WT_W-1:0] RED_WT_RST   = 16'd35542;
  localparam logic [WT_W-1:0] GREEN_WT_RST = 16'd19371;
  localparam logic [WT_W-1:0] BLUE_WT_RST  = 16'd61017;

  localparam logic [1:0] FUNC_LOAD_PAL = 2'd0;
  localparam logic [1:0] FUNC_LOAD_RES = 2'd1;
  localparam logic [1:0] FUNC_DECODE   = 2'd2;

  localparam logic [1:0] REG_RED_WT   = 2'd0;
  localparam logic [1:0] REG_GREEN_WT = 2'd1;
  localparam logic [1:0] REG_BLUE_WT  = 2'd2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] pix;
    logic       last;
  } out_item_t;

  function automatic logic [7:0] chan_round(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + HALF_LSB;
    if (p <= 0) begin
      return 8'd0;
    end else if (p > MAX_CLAMP) begin
      return 8'd255;
    end else begin
      return t[FRAC_BITS +: 8];
    end
  endfunction

endpackage

>>> sv/mvq_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mvq_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/mean_removed_vq_block_decoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mean_removed_vq_block_decoder
// Mean-removed VQ decoder: palette and residual codebooks in RAM, one pixel per cycle
// while the output FIFO has room, through read, multiply and clamp/round stages into the FIFO.
//
//   port group  direction  handshake        payload
//   in_*        input      in_valid/stall   func, entry/word, palette/res index
//   out_*       output     out_valid/stall  red, green, blue, pixel, last
//   cfg_*       input      cfg_we           cfg_index, cfg_wdata
//
// A load item is taken when idle. A decode item holds in_stall until all EMIT
// (16) pixels are issued, one residual RAM read per pixel, longer if out_stall
// backs up the 4-entry output FIFO; each pixel passes RAM read and product registers.
// Reset clears control and weights only; codebook RAMs are not cleared.
// ---------------------------------------------------------------------------
module mean_removed_vq_block_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_entry_index,
  input  logic [5:0]  in_word_position,
  input  logic signed [mvq_pkg::WORD_W-1:0] in_word_value,
  input  logic [7:0]  in_palette_index,
  input  logic [7:0]  in_residual_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [3:0]  out_pixel_in_block,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [mvq_pkg::WT_W-1:0] cfg_wdata
);
  import mvq_pkg::*;

  // config
  logic [WT_W-1:0] wt_r [NUM_CH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wt_r[0] <= RED_WT_RST;
      wt_r[1] <= GREEN_WT_RST;
      wt_r[2] <= BLUE_WT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RED_WT:   wt_r[0] <= cfg_wdata;
        REG_GREEN_WT: wt_r[1] <= cfg_wdata;
        REG_BLUE_WT:  wt_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input decode
  logic        in_acc;
  logic        entry_ok;
  logic        pos_ok;
  logic [11:0] pos_mul;
  logic [4:0]  ld_pix;
  logic [1:0]  ld_ch;
  logic [RES_AW-1:0] ld_res_addr;
  logic [PAL_AW-1:0] ld_pal_addr;

  assign in_acc   = in_valid && !in_stall;
  assign entry_ok = {24'd0, in_entry_index} < 32'(CODEBOOK_ENTRIES);
  assign pos_ok   = {26'd0, in_word_position} < 32'(WORDS_PER_BLOCK);
  // pos / 3 for pos < 64
  assign pos_mul  = {6'd0, in_word_position} * 12'd43;
  assign ld_pix   = pos_mul[11:7];
  assign ld_ch    = 2'(in_word_position - 6'(ld_pix) * 6'd3);
  assign ld_res_addr = RES_AW'(32'(in_entry_index) * PIXELS + 32'(ld_pix));
  assign ld_pal_addr = PAL_AW'(in_entry_index);

  // control
  state_t state_r, state_nxt;
  logic [CNT_W-1:0]  pix_r;
  logic [PAL_AW-1:0] pal_idx_r;
  logic [RES_AW-1:0] base_r;
  logic              pal_zero_r, res_zero_r;
  logic              issue;
  logic              start;
  logic              done_issue;
  logic [FIFO_AW:0]  fifo_cnt_r;
  logic              v_rd_r, v_mul_r;
  logic [FIFO_AW:0]  credit;

  assign start      = in_acc && (in_func == FUNC_DECODE);
  assign done_issue = issue && (32'(pix_r) == 32'(EMIT - 1));
  assign credit     = fifo_cnt_r + (FIFO_AW+1)'(v_rd_r) + (FIFO_AW+1)'(v_mul_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_RUN;
      ST_RUN:  if (done_issue) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_RUN:  issue = credit < (FIFO_AW+1)'(FIFO_DEPTH);
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pix_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (start || done_issue) begin
        pix_r <= '0;
      end else if (issue) begin
        pix_r <= pix_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pal_idx_r  <= PAL_AW'(in_palette_index);
      base_r     <= RES_AW'(32'(in_residual_index) * PIXELS);
      pal_zero_r <= {24'd0, in_palette_index} >= 32'(CODEBOOK_ENTRIES);
      res_zero_r <= {24'd0, in_residual_index} >= 32'(CODEBOOK_ENTRIES);
    end
  end

  // read stage
  logic [3:0] pix_rd_r;
  logic       last_rd_r, pz_rd_r, rz_rd_r;
  logic [3:0] pix_mul_r;
  logic       last_mul_r;
  logic signed [WORD_W-1:0] pal_q [NUM_CH];
  logic signed [WORD_W-1:0] res_q [NUM_CH];
  logic signed [PROD_W-1:0] prod_nxt [NUM_CH];
  logic signed [PROD_W-1:0] prod_r [NUM_CH];
  logic [RES_AW-1:0] rd_res_addr;

  assign rd_res_addr = base_r + RES_AW'(pix_r);

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    logic signed [SUM_W-1:0] mean_v, resid_v, sum_v;
    logic signed [WT_W:0]    wt_s;

    mvq_ram #(.WIDTH(WORD_W), .DEPTH(CODEBOOK_ENTRIES)) u_pal_ram (
      .clk   (clk),
      .we    (in_acc && in_func == FUNC_LOAD_PAL && entry_ok &&
              in_word_position == 6'(c)),
      .waddr (ld_pal_addr),
      .wdata (in_word_value),
      .re    (issue),
      .raddr (pal_idx_r),
      .rdata (pal_q[c])
    );

    mvq_ram #(.WIDTH(WORD_W), .DEPTH(RES_DEPTH)) u_res_ram (
      .clk   (clk),
      .we    (in_acc && in_func == FUNC_LOAD_RES && entry_ok && pos_ok &&
              ld_ch == 2'(c)),
      .waddr (ld_res_addr),
      .wdata (in_word_value),
      .re    (issue),
      .raddr (rd_res_addr),
      .rdata (res_q[c])
    );

    assign mean_v  = pz_rd_r ? '0 : SUM_W'(pal_q[c]);
    assign resid_v = rz_rd_r ? '0 : SUM_W'(res_q[c]);
    assign sum_v   = mean_v + resid_v;
    assign wt_s    = signed'({1'b0, wt_r[c]});
    assign prod_nxt[c] = PROD_W'(sum_v) * PROD_W'(wt_s);

    always_ff @(posedge clk) begin
      if (v_rd_r) begin
        prod_r[c] <= prod_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_rd_r  <= 1'b0;
      v_mul_r <= 1'b0;
    end else begin
      v_rd_r  <= issue;
      v_mul_r <= v_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pix_rd_r  <= 4'(pix_r);
      last_rd_r <= 32'(pix_r) == 32'(PIXELS - 1);
      pz_rd_r   <= pal_zero_r;
      rz_rd_r   <= res_zero_r;
    end
    if (v_rd_r) begin
      pix_mul_r  <= pix_rd_r;
      last_mul_r <= last_rd_r;
    end
  end

  // output FIFO
  out_item_t        fifo_r [FIFO_DEPTH];
  out_item_t        push_item;
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic             pop;

  assign push_item.red   = chan_round(prod_r[0]);
  assign push_item.green = chan_round(prod_r[1]);
  assign push_item.blue  = chan_round(prod_r[2]);
  assign push_item.pix   = pix_mul_r;
  assign push_item.last  = last_mul_r;

  assign out_valid = fifo_cnt_r != '0;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (v_mul_r) begin
      fifo_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (v_mul_r) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)     rd_ptr_r <= rd_ptr_r + 1'b1;
      fifo_cnt_r <= fifo_cnt_r + (FIFO_AW+1)'(v_mul_r) - (FIFO_AW+1)'(pop);
    end
  end

  assign out_red            = fifo_r[rd_ptr_r].red;
  assign out_green          = fifo_r[rd_ptr_r].green;
  assign out_blue           = fifo_r[rd_ptr_r].blue;
  assign out_pixel_in_block = fifo_r[rd_ptr_r].pix;
  assign out_last           = fifo_r[rd_ptr_r].last;

endmodule
